>>> hw/rtl/pcsm_pkg.sv
// pcsm_pkg: state, event, action and power codes plus the item, result and
// context structs shared by the charger manager modules
// no dependencies
`default_nettype none

package pcsm_pkg;

    localparam int LevelW = 7;

    localparam logic [LevelW-1:0] LEVEL_MAX        = 7'd100;
    localparam logic [LevelW-1:0] FULL_LEVEL_RESET = 7'd100;

    // controller states, full is a reported code only
    localparam logic [2:0] ST_RESET    = 3'd0;
    localparam logic [2:0] ST_INIT     = 3'd1;
    localparam logic [2:0] ST_ENABLED  = 3'd2;
    localparam logic [2:0] ST_DETECTED = 3'd3;
    localparam logic [2:0] ST_CHARGING = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_INITIALIZED = 4'd1;
    localparam logic [3:0] EV_ENABLED     = 4'd2;
    localparam logic [3:0] EV_DISABLED    = 4'd3;
    localparam logic [3:0] EV_DETECTED    = 4'd4;
    localparam logic [3:0] EV_LOST        = 4'd5;
    localparam logic [3:0] EV_STARTED     = 4'd6;
    localparam logic [3:0] EV_UPDATE      = 4'd7;
    localparam logic [3:0] EV_ENDED       = 4'd8;
    localparam logic [3:0] EV_STOPPED     = 4'd9;
    localparam logic [3:0] EV_ERROR       = 4'd10;
    localparam logic [3:0] EV_INITIALIZE  = 4'd11;
    localparam logic [3:0] EV_ENABLE      = 4'd12;
    localparam logic [3:0] EV_DISABLE     = 4'd13;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_INIT    = 3'd1;
    localparam logic [2:0] ACT_ENABLE  = 3'd2;
    localparam logic [2:0] ACT_DISABLE = 3'd3;
    localparam logic [2:0] ACT_QUERY   = 3'd4;

    localparam logic [1:0] DRV_OK   = 2'd0;
    localparam logic [1:0] DRV_BUSY = 2'd1;

    localparam logic [1:0] PWR_ON      = 2'd0;
    localparam logic [1:0] PWR_SUSPEND = 2'd1;

    typedef struct packed {
        logic [3:0]        event_code;
        logic [1:0]        driver_result;
        logic [1:0]        power_state;
        logic              level_valid;
        logic [LevelW-1:0] level_value;
    } item_t;

    typedef struct packed {
        logic [2:0]        next_state;
        logic [2:0]        reported_state;
        logic [LevelW-1:0] battery_level;
        logic              host_disabled;
        logic [2:0]        driver_action;
        logic              queue_enable;
        logic              notify_host;
    } result_t;

    typedef struct packed {
        logic [2:0]        ctrl_state;
        logic [LevelW-1:0] charge_level;
        logic              host_error;
    } ctx_t;

endpackage

`default_nettype wire

>>> hw/rtl/peripheral_charge_state_machine.sv
// peripheral_charge_state_machine: top level of the one-port charger manager
// holds the input register, controller context, threshold and result register;
// depends on pcsm_pkg and pcsm_step
//
//   channel   direction   handshake             payload
//   in        sink        in_valid / in_ready   event_code .. level_value
//   out       source      out_valid / out_ready next_state .. notify_host
//   cfg       sink        cfg_valid / cfg_ready cfg_data (full_level)
//
// path: an input goes to the input register, then its result to the result register
// throughput: one event per cycle unless out_ready stalls, set by the combinational
//   step logic that updates the controller context as it loads the result register
// stalls: out_ready low holds the result and then the input register;
//   in_ready falls only when both stages are full and the output is stalled
// reset: state reset, level and host flag zero, full_level 100, cfg_ready always high
`default_nettype none

module peripheral_charge_state_machine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [3:0]                    event_code,
    input  wire logic [1:0]                    driver_result,
    input  wire logic [1:0]                    power_state,
    input  wire logic                          level_valid,
    input  wire logic [pcsm_pkg::LevelW-1:0]   level_value,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         next_state,
    output logic [2:0]                         reported_state,
    output logic [pcsm_pkg::LevelW-1:0]        battery_level,
    output logic                               host_disabled,
    output logic [2:0]                         driver_action,
    output logic                               queue_enable,
    output logic                               notify_host,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pcsm_pkg::LevelW-1:0]   cfg_data
);
    import pcsm_pkg::*;

    item_t             item_reg;
    logic              item_vld_reg;
    ctx_t              ctx_reg;
    ctx_t              ctx_next;
    result_t           res_reg;
    result_t           res_next;
    logic              res_vld_reg;
    logic [LevelW-1:0] full_level_reg;
    logic              res_load;
    logic              item_load;

    assign res_load  = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready  = !item_vld_reg || res_load;
    assign item_load = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    pcsm_step u_step (
        .item       (item_reg),
        .ctx        (ctx_reg),
        .full_level (full_level_reg),
        .ctx_next   (ctx_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
            ctx_reg        <= '0;
            full_level_reg <= FULL_LEVEL_RESET;
        end
        else
        begin
            if (item_load)
                item_vld_reg <= 1'b1;
            else if (res_load)
                item_vld_reg <= 1'b0;

            if (res_load)
            begin
                res_vld_reg <= 1'b1;
                ctx_reg     <= ctx_next;
            end
            else if (out_ready)
                res_vld_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                full_level_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg.event_code    <= event_code;
            item_reg.driver_result <= driver_result;
            item_reg.power_state   <= power_state;
            item_reg.level_valid   <= level_valid;
            item_reg.level_value   <= level_value;
        end
        if (res_load)
            res_reg <= res_next;
    end

    assign out_valid      = res_vld_reg;
    assign next_state     = res_reg.next_state;
    assign reported_state = res_reg.reported_state;
    assign battery_level  = res_reg.battery_level;
    assign host_disabled  = res_reg.host_disabled;
    assign driver_action  = res_reg.driver_action;
    assign queue_enable   = res_reg.queue_enable;
    assign notify_host    = res_reg.notify_host;

    // context never leaves the five controller states
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.ctrl_state <= ST_CHARGING)
        else $error("controller state out of range");

    // full is only reported for a detected device
    a_full_detected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reported_state == ST_FULL |-> next_state == ST_DETECTED)
        else $error("full reported outside detected");

    // stored level never exceeds the clamp
    a_level_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.charge_level <= LEVEL_MAX)
        else $error("battery level above limit");

    // a queued enable always comes with the initialized state
    a_queue_init: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_enable |-> next_state == ST_INIT)
        else $error("enable queued outside initialized");

    // the result register only loads when the context advances with it
    a_ctx_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid && ctx_reg.ctrl_state == next_state)
        else $error("context and result out of step");

endmodule

`default_nettype wire

>>> hw/rtl/pcsm_step.sv
// pcsm_step: next-state and result logic for one event of the charger manager
// depends on pcsm_pkg
`default_nettype none

module pcsm_step (
    input  wire pcsm_pkg::item_t             item,
    input  wire pcsm_pkg::ctx_t              ctx,
    input  wire logic [pcsm_pkg::LevelW-1:0] full_level,
    output pcsm_pkg::ctx_t                   ctx_next,
    output pcsm_pkg::result_t                res
);
    import pcsm_pkg::*;

    logic [3:0]        ev;
    logic [2:0]        st;
    logic [LevelW-1:0] lvl;
    logic              herr;
    logic [2:0]        act;
    logic              qen;
    logic              notify;
    logic              drv_ok;
    logic              drv_busy;
    logic              init_req;
    logic              dis_req;

    always_comb
    begin
        ev       = (item.event_code > EV_DISABLE) ? EV_NONE : item.event_code;
        drv_ok   = (item.driver_result == DRV_OK);
        drv_busy = (item.driver_result == DRV_BUSY);
        st       = ctx.ctrl_state;
        herr     = ctx.host_error;
        act      = ACT_NONE;
        qen      = 1'b0;
        init_req = 1'b0;
        dis_req  = 1'b0;

        // level report lands before the event is handled
        if (item.level_valid)
            lvl = (item.level_value > LEVEL_MAX) ? LEVEL_MAX : item.level_value;
        else
            lvl = ctx.charge_level;

        case (ctx.ctrl_state)
            ST_RESET:
            begin
                if (ev == EV_INITIALIZE)
                    init_req = 1'b1;
                else if (ev == EV_INITIALIZED)
                begin
                    qen = 1'b1;
                    st  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // an enable clears a held host disable before anything else
                if (ev == EV_ENABLE)
                    herr = 1'b0;
                if (!herr)
                begin
                    if (ev == EV_INITIALIZE)
                        init_req = 1'b1;
                    else if (ev == EV_ENABLE)
                    begin
                        act = ACT_ENABLE;
                        if (drv_ok)
                            st = ST_ENABLED;
                    end
                    else if (ev == EV_ENABLED)
                        st = ST_ENABLED;
                end
            end
            ST_ENABLED:
            begin
                if (ev == EV_INITIALIZE)
                    init_req = 1'b1;
                else if (ev == EV_DISABLE)
                    dis_req = 1'b1;
                else if (ev == EV_DISABLED)
                    st = ST_INIT;
                else if (ev == EV_DETECTED)
                begin
                    act = ACT_QUERY;
                    st  = ST_DETECTED;
                end
                else if (ev == EV_STARTED)
                    st = ST_CHARGING;
            end
            ST_DETECTED, ST_CHARGING:
            begin
                if (ev == EV_INITIALIZE)
                    init_req = 1'b1;
                else if (ev == EV_DISABLE)
                    dis_req = 1'b1;
                else if (ev == EV_DISABLED || ev == EV_ERROR)
                    st = ST_INIT;
                else if (ev == EV_LOST)
                begin
                    lvl = '0;
                    st  = ST_ENABLED;
                end
                else if (ctx.ctrl_state == ST_DETECTED && ev == EV_STARTED)
                    st = ST_CHARGING;
                else if (ctx.ctrl_state == ST_CHARGING &&
                         (ev == EV_ENDED || ev == EV_STOPPED))
                    st = ST_DETECTED;
            end
            default:
            begin
                st = ctx.ctrl_state;
            end
        endcase

        if (init_req)
        begin
            act  = ACT_INIT;
            lvl  = '0;
            herr = 1'b0;
            if (drv_ok)
            begin
                qen = 1'b1;
                st  = ST_INIT;
            end
            else if (drv_busy)
                st = ST_RESET;
        end

        if (dis_req)
        begin
            herr = 1'b1;
            act  = ACT_DISABLE;
            if (drv_ok)
                st = ST_INIT;
        end

        case (item.power_state)
            PWR_ON:      notify = (ev != EV_NONE);
            PWR_SUSPEND: notify = (ev == EV_DETECTED || ev == EV_LOST);
            default:     notify = 1'b0;
        endcase

        ctx_next.ctrl_state   = st;
        ctx_next.charge_level = lvl;
        ctx_next.host_error   = herr;

        res.next_state     = st;
        res.reported_state = (st == ST_DETECTED && lvl >= full_level) ? ST_FULL : st;
        res.battery_level  = lvl;
        res.host_disabled  = herr;
        res.driver_action  = act;
        res.queue_enable   = qen;
        res.notify_host    = notify;
    end

endmodule

`default_nettype wire

>>> tb/charge_event_checker.sv
// charge_event_checker: watches the event, result and threshold channels of the
// charger manager, predicts each result and compares it field by field
// depends on pcsm_pkg
module charge_event_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic [3:0]                  event_code,
    input  wire logic [1:0]                  driver_result,
    input  wire logic [1:0]                  power_state,
    input  wire logic                        level_valid,
    input  wire logic [pcsm_pkg::LevelW-1:0] level_value,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [2:0]                  next_state,
    input  wire logic [2:0]                  reported_state,
    input  wire logic [pcsm_pkg::LevelW-1:0] battery_level,
    input  wire logic                        host_disabled,
    input  wire logic [2:0]                  driver_action,
    input  wire logic                        queue_enable,
    input  wire logic                        notify_host,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [pcsm_pkg::LevelW-1:0] cfg_data,
    output int                               mismatch_count,
    output int                               results_due
);
    import pcsm_pkg::*;

    // shadow copy of the manager context and threshold
    logic [2:0]        mgr_state;
    logic [LevelW-1:0] mgr_level;
    logic              mgr_host_err;
    logic [LevelW-1:0] mgr_full_level;

    result_t due_results[$];
    result_t want;
    result_t got;
    int      errs;

    function automatic result_t charge_step_result(input item_t it);
        logic [3:0] ev;
        logic [2:0] nxt;
        logic       run_init;
        logic       run_disable;
        result_t    r;
        ev = (it.event_code > EV_DISABLE) ? EV_NONE : it.event_code;
        nxt = mgr_state;
        run_init = 1'b0;
        run_disable = 1'b0;
        r = '0;
        // a level report lands before the event is handled
        if (it.level_valid)
            mgr_level = (it.level_value > LEVEL_MAX) ? LEVEL_MAX : it.level_value;
        case (mgr_state)
            ST_RESET:
            begin
                if (ev == EV_INITIALIZE)
                    run_init = 1'b1;
                else if (ev == EV_INITIALIZED)
                begin
                    r.queue_enable = 1'b1;
                    nxt = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (ev == EV_ENABLE)
                    mgr_host_err = 1'b0;
                // a held host disable swallows everything else here
                if (!mgr_host_err)
                begin
                    if (ev == EV_INITIALIZE)
                        run_init = 1'b1;
                    else if (ev == EV_ENABLE)
                    begin
                        r.driver_action = ACT_ENABLE;
                        if (it.driver_result == DRV_OK)
                            nxt = ST_ENABLED;
                    end
                    else if (ev == EV_ENABLED)
                        nxt = ST_ENABLED;
                end
            end
            ST_ENABLED:
            begin
                if (ev == EV_INITIALIZE)
                    run_init = 1'b1;
                else if (ev == EV_DISABLE)
                    run_disable = 1'b1;
                else if (ev == EV_DISABLED)
                    nxt = ST_INIT;
                else if (ev == EV_DETECTED)
                begin
                    r.driver_action = ACT_QUERY;
                    nxt = ST_DETECTED;
                end
                else if (ev == EV_STARTED)
                    nxt = ST_CHARGING;
            end
            ST_DETECTED, ST_CHARGING:
            begin
                if (ev == EV_INITIALIZE)
                    run_init = 1'b1;
                else if (ev == EV_DISABLE)
                    run_disable = 1'b1;
                else if (ev == EV_DISABLED || ev == EV_ERROR)
                    nxt = ST_INIT;
                else if (ev == EV_LOST)
                begin
                    mgr_level = '0;
                    nxt = ST_ENABLED;
                end
                else if (mgr_state == ST_DETECTED && ev == EV_STARTED)
                    nxt = ST_CHARGING;
                else if (mgr_state == ST_CHARGING && (ev == EV_ENDED || ev == EV_STOPPED))
                    nxt = ST_DETECTED;
            end
            default:
            begin
            end
        endcase
        if (run_init)
        begin
            r.driver_action = ACT_INIT;
            if (it.driver_result == DRV_OK)
            begin
                r.queue_enable = 1'b1;
                nxt = ST_INIT;
            end
            else if (it.driver_result == DRV_BUSY)
                nxt = ST_RESET;
            mgr_level = '0;
            mgr_host_err = 1'b0;
        end
        if (run_disable)
        begin
            mgr_host_err = 1'b1;
            r.driver_action = ACT_DISABLE;
            if (it.driver_result == DRV_OK)
                nxt = ST_INIT;
        end
        mgr_state = nxt;
        if (it.power_state == PWR_ON)
            r.notify_host = (ev != EV_NONE);
        else if (it.power_state == PWR_SUSPEND)
            r.notify_host = (ev == EV_DETECTED || ev == EV_LOST);
        r.next_state = nxt;
        r.reported_state = (nxt == ST_DETECTED && mgr_level >= mgr_full_level) ? ST_FULL : nxt;
        r.battery_level = mgr_level;
        r.host_disabled = mgr_host_err;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mgr_state = ST_RESET;
            mgr_level = '0;
            mgr_host_err = 1'b0;
            mgr_full_level = FULL_LEVEL_RESET;
            due_results.delete();
            errs = 0;
            mismatch_count <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mgr_full_level = cfg_data;
            if (out_valid && out_ready)
            begin
                got = {next_state, reported_state, battery_level, host_disabled,
                       driver_action, queue_enable, notify_host};
                if (due_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: next_state %0d", next_state);
                    errs++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.next_state !== want.next_state)
                    begin
                        $error("next_state: expected %0d, got %0d", want.next_state, got.next_state);
                        errs++;
                    end
                    if (got.reported_state !== want.reported_state)
                    begin
                        $error("reported_state: expected %0d, got %0d",
                               want.reported_state, got.reported_state);
                        errs++;
                    end
                    if (got.battery_level !== want.battery_level)
                    begin
                        $error("battery_level: expected %0d, got %0d",
                               want.battery_level, got.battery_level);
                        errs++;
                    end
                    if (got.host_disabled !== want.host_disabled)
                    begin
                        $error("host_disabled: expected %0d, got %0d",
                               want.host_disabled, got.host_disabled);
                        errs++;
                    end
                    if (got.driver_action !== want.driver_action)
                    begin
                        $error("driver_action: expected %0d, got %0d",
                               want.driver_action, got.driver_action);
                        errs++;
                    end
                    if (got.queue_enable !== want.queue_enable)
                    begin
                        $error("queue_enable: expected %0d, got %0d",
                               want.queue_enable, got.queue_enable);
                        errs++;
                    end
                    if (got.notify_host !== want.notify_host)
                    begin
                        $error("notify_host: expected %0d, got %0d",
                               want.notify_host, got.notify_host);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                due_results.push_back(charge_step_result({event_code, driver_result,
                    power_state, level_valid, level_value}));
            results_due <= due_results.size();
            mismatch_count <= errs;
        end
    end

endmodule

>>> tb/tb_top.sv
// tb_top: drives charger manager events and threshold writes with random idling
// and a long output stall, and reports the verdict of charge_event_checker
// depends on pcsm_pkg, peripheral_charge_state_machine and charge_event_checker
module tb_top;

    import pcsm_pkg::*;

    localparam logic [1:0] DRV_FAIL  = 2'd2;
    localparam logic [1:0] DRV_UNDEF = 2'd3;
    localparam logic [1:0] PWR_OFF   = 2'd2;
    localparam logic [1:0] PWR_UNDEF = 2'd3;

    localparam int PHASE_ITEMS  = 220;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 1000;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [3:0]        event_code = EV_NONE;
    logic [1:0]        driver_result = DRV_OK;
    logic [1:0]        power_state = PWR_ON;
    logic              level_valid = 1'b0;
    logic [LevelW-1:0] level_value = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        next_state;
    logic [2:0]        reported_state;
    logic [LevelW-1:0] battery_level;
    logic              host_disabled;
    logic [2:0]        driver_action;
    logic              queue_enable;
    logic              notify_host;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LevelW-1:0] cfg_data = FULL_LEVEL_RESET;

    int fail_count;
    int results_due;
    int events_sent = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    peripheral_charge_state_machine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .event_code     (event_code),
        .driver_result  (driver_result),
        .power_state    (power_state),
        .level_valid    (level_valid),
        .level_value    (level_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_state     (next_state),
        .reported_state (reported_state),
        .battery_level  (battery_level),
        .host_disabled  (host_disabled),
        .driver_action  (driver_action),
        .queue_enable   (queue_enable),
        .notify_host    (notify_host),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    charge_event_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .event_code     (event_code),
        .driver_result  (driver_result),
        .power_state    (power_state),
        .level_valid    (level_valid),
        .level_value    (level_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_state     (next_state),
        .reported_state (reported_state),
        .battery_level  (battery_level),
        .host_disabled  (host_disabled),
        .driver_action  (driver_action),
        .queue_enable   (queue_enable),
        .notify_host    (notify_host),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (fail_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic item_t mk_item(input logic [3:0] ev, input logic [1:0] drv,
                                      input logic [1:0] pwr, input logic lv,
                                      input logic [LevelW-1:0] lval);
        item_t it;
        it.event_code = ev;
        it.driver_result = drv;
        it.power_state = pwr;
        it.level_valid = lv;
        it.level_value = lval;
        return it;
    endfunction

    // well-formed event: legal power code, level within percent range
    function automatic item_t make_event(input logic [3:0] ev, input logic [1:0] drv);
        return mk_item(ev, drv, 2'($urandom_range(2, 0)), 1'($urandom_range(1, 0)),
                       LevelW'($urandom_range(100, 0)));
    endfunction

    function automatic logic [1:0] pick_drv();
        int roll;
        roll = $urandom_range(19, 0);
        if (roll < 14)
            return DRV_OK;
        if (roll < 17)
            return DRV_BUSY;
        if (roll < 19)
            return DRV_FAIL;
        return DRV_UNDEF;
    endfunction

    // valid stays up across back-to-back transfers, dropped only ahead of a gap
    task automatic send_event(input item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(18, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        event_code <= it.event_code;
        driver_result <= it.driver_result;
        power_state <= it.power_state;
        level_valid <= it.level_valid;
        level_value <= it.level_value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic send_noise();
        logic [$bits(item_t)-1:0] raw;
        raw = $bits(item_t)'($urandom);
        send_event(item_t'(raw));
    endtask

    task automatic write_full_level(input logic [LevelW-1:0] lvl);
        cfg_valid <= 1'b1;
        cfg_data <= lvl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every result, then let the pipeline settle
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // init, enable, then a few detect / charge / unplug rounds
    task automatic run_charge_session();
        logic [3:0] charge_evs [4];
        logic [3:0] end_evs [4];
        int         n;
        charge_evs = '{EV_STARTED, EV_UPDATE, EV_ENDED, EV_STOPPED};
        end_evs = '{EV_LOST, EV_ERROR, EV_DISABLE, EV_DISABLED};
        if ($urandom_range(3, 0) == 0)
            send_event(make_event(EV_INITIALIZED, pick_drv()));
        else
            send_event(make_event(EV_INITIALIZE, pick_drv()));
        send_event(make_event(EV_ENABLE, pick_drv()));
        if ($urandom_range(3, 0) == 0)
            send_event(make_event(EV_ENABLED, pick_drv()));
        repeat ($urandom_range(3, 1))
        begin
            send_event(make_event(EV_DETECTED, pick_drv()));
            n = $urandom_range(5, 0);
            repeat (n)
            begin
                if ($urandom_range(7, 0) == 0)
                    send_event(make_event(4'($urandom_range(15, 0)), pick_drv()));
                else
                    send_event(make_event(charge_evs[$urandom_range(3, 0)], pick_drv()));
            end
            send_event(make_event(end_evs[$urandom_range(3, 0)], pick_drv()));
            send_event(make_event(EV_ENABLE, pick_drv()));
        end
    endtask

    // output side: random hold-off per result, or a long hold when asked
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = steady ? 0 : $urandom_range(18, 0);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int                phase_start;
        logic [LevelW-1:0] thresh;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through every state with the threshold at reset
        send_event(mk_item(EV_NONE, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_INITIALIZED, DRV_FAIL, PWR_SUSPEND, 1'b0, 7'd127));
        send_event(mk_item(EV_ENABLED, DRV_OK, PWR_OFF, 1'b0, 7'd0));
        send_event(mk_item(EV_DETECTED, DRV_OK, PWR_SUSPEND, 1'b1, 7'd127));
        send_event(mk_item(EV_STARTED, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_UPDATE, DRV_OK, PWR_UNDEF, 1'b1, 7'd0));
        send_event(mk_item(EV_ENDED, DRV_OK, PWR_ON, 1'b1, 7'd100));
        send_event(mk_item(EV_STARTED, DRV_OK, PWR_SUSPEND, 1'b0, 7'd0));
        send_event(mk_item(EV_STOPPED, DRV_OK, PWR_ON, 1'b1, 7'd42));
        send_event(mk_item(EV_LOST, DRV_OK, PWR_SUSPEND, 1'b1, 7'd55));
        send_event(mk_item(EV_DISABLE, DRV_FAIL, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_DISABLED, DRV_OK, PWR_ON, 1'b1, 7'd80));
        // host disable held: ignored until an enable
        send_event(mk_item(EV_ENABLED, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_INITIALIZE, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_ENABLE, DRV_BUSY, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_ENABLE, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_INITIALIZE, DRV_BUSY, PWR_OFF, 1'b1, 7'd77));
        send_event(mk_item(EV_INITIALIZE, DRV_FAIL, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_INITIALIZE, DRV_UNDEF, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_INITIALIZE, DRV_OK, PWR_ON, 1'b1, 7'd99));
        send_event(mk_item(4'd14, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(4'd15, DRV_OK, PWR_SUSPEND, 1'b0, 7'd0));
        send_event(mk_item(EV_ENABLE, DRV_OK, PWR_ON, 1'b0, 7'd0));
        send_event(mk_item(EV_DETECTED, DRV_OK, PWR_ON, 1'b1, 7'd99));
        send_event(mk_item(EV_DISABLE, DRV_OK, PWR_ON, 1'b0, 7'd0));
        drain_results(4);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: thresh = 7'd0;
                1: thresh = 7'd127;
                2: thresh = 7'd101;
                3: thresh = 7'd50;
                4: thresh = 7'd1;
                5: thresh = LevelW'($urandom_range(100, 0));
                6: thresh = LevelW'($urandom_range(127, 0));
                default: thresh = 7'd100;
            endcase
            write_full_level(thresh);
            if (p == 3)
            begin
                // fill the block while the output is held off
                hold_req = 1'b1;
                steady = 1'b1;
                repeat (12) send_event(make_event(4'($urandom_range(13, 0)), pick_drv()));
            end
            phase_start = events_sent;
            while (events_sent - phase_start < PHASE_ITEMS)
            begin
                steady = ($urandom_range(4, 0) == 0);
                if ($urandom_range(9, 0) < 7)
                    run_charge_session();
                else
                    repeat ($urandom_range(6, 1)) send_noise();
            end
            steady = 1'b0;
            drain_results(4);
        end

        drain_results(8);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
